// File: rtl/cbf_pkg.sv
// Shared types, constants and width helpers of the Bezier flattener.
`timescale 1ns / 1ps

package cbf_pkg;

    // Default number of line segments per curve (legal range 1 to 63).
    localparam int SEGMENTS_DEF = 20;

    // Field widths.
    localparam int COORD_W   = 16;
    localparam int DPI_W     = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ENABLED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DPI_X   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DPI_Y   = 2'd2;

    // Reset values of the scale registers.
    localparam logic [DPI_W-1:0] DPI_RESET = 8'd100;

    // Live configuration seen by the front and back parts.
    typedef struct packed {
        logic             enabled;
        logic [DPI_W-1:0] dpi_x;
        logic [DPI_W-1:0] dpi_y;
    } t_cfg;

    // Per-point flags carried down the output pipeline.
    typedef struct packed {
        logic is_cut;
        logic final_point;
        logic accepted;
    } t_flags;

    // Bits needed to hold SEGMENTS cubed.
    function automatic int cube_width(input int segs);
        return $clog2(segs * segs * segs + 1);
    endfunction

    // Width of the forward-difference accumulators.
    function automatic int acc_width(input int segs);
        return cube_width(segs) + 22;
    endfunction

    // Queue entry: enable flag plus start value and three differences per axis.
    function automatic int entry_width(input int segs);
        return 8 * acc_width(segs) + 1;
    endfunction

endpackage

// File: rtl/cbf_curve_if.sv
// Curve input channel: four control points in signed Q7.8 inches.
`timescale 1ns / 1ps

interface cbf_curve_if;
    logic                                valid;
    logic                                ready;
    logic signed [cbf_pkg::COORD_W-1:0] start_x;
    logic signed [cbf_pkg::COORD_W-1:0] start_y;
    logic signed [cbf_pkg::COORD_W-1:0] ctrl1_x;
    logic signed [cbf_pkg::COORD_W-1:0] ctrl1_y;
    logic signed [cbf_pkg::COORD_W-1:0] ctrl2_x;
    logic signed [cbf_pkg::COORD_W-1:0] ctrl2_y;
    logic signed [cbf_pkg::COORD_W-1:0] end_x;
    logic signed [cbf_pkg::COORD_W-1:0] end_y;

    modport source (output valid, start_x, start_y, ctrl1_x, ctrl1_y,
                    ctrl2_x, ctrl2_y, end_x, end_y, input ready);
    modport sink   (input valid, start_x, start_y, ctrl1_x, ctrl1_y,
                    ctrl2_x, ctrl2_y, end_x, end_y, output ready);
endinterface

// File: rtl/cbf_point_if.sv
// Path point output channel: dot coordinates and point flags.
`timescale 1ns / 1ps

interface cbf_point_if;
    logic                                valid;
    logic                                ready;
    logic signed [cbf_pkg::COORD_W-1:0] x_dots;
    logic signed [cbf_pkg::COORD_W-1:0] y_dots;
    logic                                is_cut;
    logic                                final_point;
    logic                                accepted;

    modport source (output valid, x_dots, y_dots, is_cut, final_point, accepted,
                    input ready);
    modport sink   (input valid, x_dots, y_dots, is_cut, final_point, accepted,
                    output ready);
endinterface

// File: rtl/cbf_cfg_if.sv
// Configuration write channel: register index and write data.
`timescale 1ns / 1ps

interface cbf_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [cbf_pkg::CFG_IDX_W-1:0]    reg_index;
    logic [cbf_pkg::CFG_DAT_W-1:0]    wr_data;

    modport source (output valid, reg_index, wr_data, input ready);
    modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

// File: rtl/cbf_front.sv
// Front part: takes curves, forms coefficients and forward-difference seeds.
`timescale 1ns / 1ps

module cbf_front #(
    parameter int  SEGMENTS = cbf_pkg::SEGMENTS_DEF,
    localparam int ENT_W    = cbf_pkg::entry_width(SEGMENTS)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cbf_pkg::t_cfg      i_cfg,
    cbf_curve_if.sink          i_curve,
    input  logic               i_full,
    output logic               o_push,
    output logic [ENT_W-1:0]   o_entry
);

    localparam int ACC_W = cbf_pkg::acc_width(SEGMENTS);
    localparam int CO_W  = 21;
    localparam int PT_W  = cbf_pkg::COORD_W;

    localparam logic signed [CO_W-1:0]  THREE   = CO_W'(3);
    localparam logic signed [ACC_W-1:0] SEG_A   = ACC_W'(SEGMENTS);
    localparam logic signed [ACC_W-1:0] SEG2_A  = ACC_W'(SEGMENTS * SEGMENTS);
    localparam logic signed [ACC_W-1:0] SEG3_A  = ACC_W'(SEGMENTS * SEGMENTS * SEGMENTS);
    localparam logic signed [ACC_W-1:0] TWOSEG_A = ACC_W'(2 * SEGMENTS);
    localparam logic signed [ACC_W-1:0] SIX_A   = ACC_W'(6);

    logic                   r_f_valid;
    logic                   r_f_en;
    logic signed [PT_W-1:0] r_f_p0 [2];
    logic signed [CO_W-1:0] r_f_c  [2];
    logic signed [CO_W-1:0] r_f_b  [2];
    logic signed [CO_W-1:0] r_f_a  [2];

    logic                   accept;
    logic signed [PT_W-1:0] pt [2][4];
    logic signed [CO_W-1:0] c_new [2];
    logic signed [CO_W-1:0] b_new [2];
    logic signed [CO_W-1:0] a_new [2];
    logic signed [ACC_W-1:0] seed [2][4];

    // Hold a curve until the queue takes its seeds.
    assign i_curve.ready = !r_f_valid || !i_full;
    assign accept        = i_curve.valid && i_curve.ready;
    assign o_push        = r_f_valid && !i_full;

    assign pt[0][0] = i_curve.start_x;
    assign pt[0][1] = i_curve.ctrl1_x;
    assign pt[0][2] = i_curve.ctrl2_x;
    assign pt[0][3] = i_curve.end_x;
    assign pt[1][0] = i_curve.start_y;
    assign pt[1][1] = i_curve.ctrl1_y;
    assign pt[1][2] = i_curve.ctrl2_y;
    assign pt[1][3] = i_curve.end_y;

    // Form the polynomial coefficients per axis.
    always_comb begin
        for (int a = 0; a < 2; a++) begin
            c_new[a] = THREE * (CO_W'(pt[a][1]) - CO_W'(pt[a][0]));
            b_new[a] = THREE * (CO_W'(pt[a][2]) - CO_W'(pt[a][1])) - c_new[a];
            a_new[a] = (CO_W'(pt[a][3]) - CO_W'(pt[a][0])) - c_new[a] - b_new[a];
        end
    end

    // Capture coefficients; a rejected curve carries all-zero values.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else if (accept) begin
            r_f_valid <= 1'b1;
        end else if (o_push) begin
            r_f_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_f_en <= i_cfg.enabled;
            for (int a = 0; a < 2; a++) begin
                r_f_p0[a] <= i_cfg.enabled ? pt[a][0] : '0;
                r_f_c[a]  <= i_cfg.enabled ? c_new[a] : '0;
                r_f_b[a]  <= i_cfg.enabled ? b_new[a] : '0;
                r_f_a[a]  <= i_cfg.enabled ? a_new[a] : '0;
            end
        end
    end

    // Seeds in units of 1/SEGMENTS^3: start value and three differences.
    always_comb begin
        for (int a = 0; a < 2; a++) begin
            seed[a][0] = ACC_W'(r_f_p0[a]) * SEG3_A;
            seed[a][1] = ACC_W'(r_f_c[a]) * SEG2_A + ACC_W'(r_f_b[a]) * SEG_A
                         + ACC_W'(r_f_a[a]);
            seed[a][2] = ACC_W'(r_f_b[a]) * TWOSEG_A + ACC_W'(r_f_a[a]) * SIX_A;
            seed[a][3] = ACC_W'(r_f_a[a]) * SIX_A;
        end
    end

    always_comb begin
        o_entry[ENT_W-1] = r_f_en;
        for (int a = 0; a < 2; a++) begin
            for (int f = 0; f < 4; f++) begin
                o_entry[(a*4+f)*ACC_W +: ACC_W] = seed[a][f];
            end
        end
    end

endmodule

// File: rtl/cbf_queue.sv
// Two-entry queue between the front and back parts.
`timescale 1ns / 1ps

module cbf_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];

    // Advance pointers and count on each transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// File: rtl/cbf_back.sv
// Back part: steps each curve by forward differences, scales and rounds points.
`timescale 1ns / 1ps

module cbf_back #(
    parameter int  SEGMENTS = cbf_pkg::SEGMENTS_DEF,
    localparam int ENT_W    = cbf_pkg::entry_width(SEGMENTS)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  cbf_pkg::t_cfg    i_cfg,
    input  logic             i_q_valid,
    input  logic [ENT_W-1:0] i_entry,
    output logic             o_pop,
    cbf_point_if.source      o_point
);

    localparam int     KW     = cbf_pkg::cube_width(SEGMENTS);
    localparam int     ACC_W  = cbf_pkg::acc_width(SEGMENTS);
    localparam int     CNT_W  = $clog2(SEGMENTS + 1);
    localparam longint K_L    = longint'(SEGMENTS) * SEGMENTS * SEGMENTS;
    // floor(log2 K): the low bits dropped before the reciprocal multiply
    localparam int     H      = KW - 1;
    localparam int     MW     = KW + 17;
    localparam int     T_W    = MW - H;
    localparam int     L2     = 17;
    localparam int     R_W    = 18;
    localparam longint R_L    = (longint'(1) << (L2 + H)) / K_L;
    localparam int     PROD_W = T_W + R_W;
    localparam int     Q_W    = PROD_W - L2;
    localparam int     N_W    = ACC_W + cbf_pkg::DPI_W + 1;
    localparam int     FULL_W = KW + Q_W;
    localparam int     REM_W  = KW + 2;
    localparam int     OW     = cbf_pkg::COORD_W;

    localparam logic [R_W-1:0]        RECIP   = R_W'(R_L);
    localparam logic signed [N_W-1:0] HALF_D  = N_W'(128 * K_L);
    localparam logic signed [N_W-1:0] OFFSET  = N_W'(32768 * K_L);
    localparam logic [REM_W-1:0]      K_REM   = REM_W'(K_L);
    localparam logic [REM_W-1:0]      K2_REM  = REM_W'(2 * K_L);
    localparam logic [FULL_W-1:0]     K_FULL  = FULL_W'(K_L);
    localparam logic [CNT_W-1:0]      LAST_I  = CNT_W'(SEGMENTS);
    localparam logic [OW-1:0]         BIAS    = OW'(32768);

    // Point generator state
    logic                    r_busy;
    logic                    r_en;
    logic [CNT_W-1:0]        r_cnt;
    logic signed [ACC_W-1:0] r_p  [2];
    logic signed [ACC_W-1:0] r_d1 [2];
    logic signed [ACC_W-1:0] r_d2 [2];
    logic signed [ACC_W-1:0] r_d3 [2];

    // Scaling pipeline
    logic                    r_s1_valid, r_s2_valid, r_s3_valid, r_o_valid;
    cbf_pkg::t_flags         r_s1_fl, r_s2_fl, r_s3_fl, r_o_fl;
    logic [MW-1:0]           r_s1_m  [2];
    logic [MW-1:0]           r_s2_m  [2];
    logic [Q_W-1:0]          r_s2_qe [2];
    logic [Q_W-1:0]          r_s3_qe [2];
    logic [REM_W-1:0]        r_s3_rem [2];
    logic [OW-1:0]           r_o_val [2];

    logic                    adv;
    logic                    gen_last;
    logic                    take_next;
    logic [cbf_pkg::DPI_W-1:0] dpi [2];
    logic signed [N_W-1:0]   n_scaled [2];
    logic [PROD_W-1:0]       prod [2];
    logic [FULL_W-1:0]       rem_full [2];
    logic [Q_W-1:0]          q_fix [2];
    cbf_pkg::t_flags         gen_fl;

    // The whole pipe moves when the output register is free or being taken.
    assign adv       = !r_o_valid || o_point.ready;
    assign gen_last  = !r_en || (r_cnt == LAST_I);
    assign take_next = adv && (!r_busy || gen_last);
    assign o_pop     = take_next && i_q_valid;

    assign dpi[0] = i_cfg.dpi_x;
    assign dpi[1] = i_cfg.dpi_y;

    assign gen_fl.is_cut      = (r_cnt != '0);
    assign gen_fl.final_point = gen_last;
    assign gen_fl.accepted    = r_en;

    // Load the next curve or step the differences.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (take_next) begin
            r_busy <= i_q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_en  <= i_entry[ENT_W-1];
            r_cnt <= '0;
            for (int a = 0; a < 2; a++) begin
                r_p[a]  <= i_entry[(a*4+0)*ACC_W +: ACC_W];
                r_d1[a] <= i_entry[(a*4+1)*ACC_W +: ACC_W];
                r_d2[a] <= i_entry[(a*4+2)*ACC_W +: ACC_W];
                r_d3[a] <= i_entry[(a*4+3)*ACC_W +: ACC_W];
            end
        end else if (adv && r_busy) begin
            r_cnt <= r_cnt + CNT_W'(1);
            for (int a = 0; a < 2; a++) begin
                r_p[a]  <= r_p[a] + r_d1[a];
                r_d1[a] <= r_d1[a] + r_d2[a];
                r_d2[a] <= r_d2[a] + r_d3[a];
            end
        end
    end

    // Scale by dpi, add half a dot, drop the 1/256, bias to non-negative.
    always_comb begin
        for (int a = 0; a < 2; a++) begin
            n_scaled[a] = N_W'(r_p[a]) * N_W'($signed({1'b0, dpi[a]}));
            n_scaled[a] = ((n_scaled[a] + HALF_D) >>> 8) + OFFSET;
        end
    end

    // Estimate the quotient by K from the top bits times a reciprocal.
    always_comb begin
        for (int a = 0; a < 2; a++) begin
            prod[a] = PROD_W'(r_s1_m[a][MW-1:H]) * PROD_W'(RECIP);
        end
    end

    // Remainder of the estimate, then the correction of up to two.
    always_comb begin
        for (int a = 0; a < 2; a++) begin
            rem_full[a] = FULL_W'(r_s2_m[a]) - FULL_W'(r_s2_qe[a]) * K_FULL;
            if (r_s3_rem[a] >= K2_REM) begin
                q_fix[a] = r_s3_qe[a] + Q_W'(2);
            end else if (r_s3_rem[a] >= K_REM) begin
                q_fix[a] = r_s3_qe[a] + Q_W'(1);
            end else begin
                q_fix[a] = r_s3_qe[a];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= r_busy;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_o_valid  <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_fl <= gen_fl;
            r_s2_fl <= r_s1_fl;
            r_s3_fl <= r_s2_fl;
            r_o_fl  <= r_s3_fl;
            for (int a = 0; a < 2; a++) begin
                r_s1_m[a]   <= n_scaled[a][MW-1:0];
                r_s2_m[a]   <= r_s1_m[a];
                r_s2_qe[a]  <= prod[a][PROD_W-1:L2];
                r_s3_qe[a]  <= r_s2_qe[a];
                r_s3_rem[a] <= rem_full[a][REM_W-1:0];
                // Remove the bias of 32768 dots.
                r_o_val[a]  <= q_fix[a][OW-1:0] ^ BIAS;
            end
        end
    end

    assign o_point.valid       = r_o_valid;
    assign o_point.x_dots      = r_o_val[0];
    assign o_point.y_dots      = r_o_val[1];
    assign o_point.is_cut      = r_o_fl.is_cut;
    assign o_point.final_point = r_o_fl.final_point;
    assign o_point.accepted    = r_o_fl.accepted;

endmodule

// File: rtl/cubic_bezier_flattener_core.sv
// Top level of the cubic Bezier flattener: config registers and the two parts.
//
//  Channel    Direction  Transfer moves
//  i_curve    in         four control points, signed Q7.8 inches
//  o_point    out        one path point in dots with is_cut/final/accepted
//  i_cfg      in         one register write (index, data), always ready
//
//  An enabled curve gives SEGMENTS+1 points, one per cycle from the single
//  output register while the output is not stalled; a rejected curve gives
//  one point. The first point passes the front register, the queue, the
//  generator, three scaling stages and the output register. A two-entry
//  queue lets the front take new curves while the back still emits; an
//  output stall freezes the back pipeline in place.
//  Reset is synchronous, active low, and empties all stages.
`timescale 1ns / 1ps

module cubic_bezier_flattener_core #(
    parameter int SEGMENTS = cbf_pkg::SEGMENTS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    cbf_curve_if.sink    i_curve,
    cbf_point_if.source  o_point,
    cbf_cfg_if.sink      i_cfg
);

    localparam int ENT_W = cbf_pkg::entry_width(SEGMENTS);

    cbf_pkg::t_cfg    r_cfg;
    logic             push;
    logic             pop;
    logic             q_full;
    logic             q_valid;
    logic [ENT_W-1:0] push_entry;
    logic [ENT_W-1:0] head_entry;

    // Take register writes at any time.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enabled <= 1'b0;
            r_cfg.dpi_x   <= cbf_pkg::DPI_RESET;
            r_cfg.dpi_y   <= cbf_pkg::DPI_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.reg_index)
                cbf_pkg::REG_ENABLED: r_cfg.enabled <= i_cfg.wr_data[0];
                cbf_pkg::REG_DPI_X:   r_cfg.dpi_x   <= i_cfg.wr_data;
                cbf_pkg::REG_DPI_Y:   r_cfg.dpi_y   <= i_cfg.wr_data;
                default: begin
                end
            endcase
        end
    end

    cbf_front #(.SEGMENTS(SEGMENTS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_curve (i_curve),
        .i_full  (q_full),
        .o_push  (push),
        .o_entry (push_entry)
    );

    cbf_queue #(.WIDTH(ENT_W)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_entry),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (head_entry)
    );

    cbf_back #(.SEGMENTS(SEGMENTS)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .i_entry   (head_entry),
        .o_pop     (pop),
        .o_point   (o_point)
    );

endmodule

// File: rtl/cbf_checker.sv
// Port-level checks of the Bezier flattener and their bind to the top level.
`timescale 1ns / 1ps

module cbf_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                i_in_ready,
    input logic                                i_out_valid,
    input logic                                i_out_ready,
    input logic signed [cbf_pkg::COORD_W-1:0] i_x_dots,
    input logic signed [cbf_pkg::COORD_W-1:0] i_y_dots,
    input logic                                i_is_cut,
    input logic                                i_final_point,
    input logic                                i_accepted
);

    logic       in_xfer;
    logic       out_xfer;
    logic       r_mid;
    logic [4:0] r_pending;

    assign in_xfer  = i_in_valid && i_in_ready;
    assign out_xfer = i_out_valid && i_out_ready;

    // Track curves in flight and whether a path is open.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid     <= 1'b0;
            r_pending <= '0;
        end else begin
            if (out_xfer) begin
                r_mid <= !i_final_point;
            end
            if (in_xfer && !(out_xfer && i_final_point)) begin
                r_pending <= r_pending + 5'd1;
            end else if (!in_xfer && out_xfer && i_final_point) begin
                r_pending <= r_pending - 5'd1;
            end
        end
    end

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_x_dots) && $stable(i_y_dots) &&
            $stable(i_is_cut) && $stable(i_final_point))
        else $error("stalled point changed");

    a_reject_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_accepted |->
            i_final_point && !i_is_cut && i_x_dots == '0 && i_y_dots == '0)
        else $error("malformed rejection");

    a_path_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer |-> (i_is_cut == r_mid))
        else $error("move or cut out of order");

    a_final_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer && i_final_point |-> r_pending != '0)
        else $error("final point without a curve");

endmodule

bind cubic_bezier_flattener_core cbf_checker u_cbf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_curve.valid),
    .i_in_ready    (i_curve.ready),
    .i_out_valid   (o_point.valid),
    .i_out_ready   (o_point.ready),
    .i_x_dots      (o_point.x_dots),
    .i_y_dots      (o_point.y_dots),
    .i_is_cut      (o_point.is_cut),
    .i_final_point (o_point.final_point),
    .i_accepted    (o_point.accepted)
);

// File: bench/cubic_bezier_flattener_core_tb.sv
// Self-checking bench for the cubic Bezier flattener core with its own point predictor.
`timescale 1ns / 1ps

module cubic_bezier_flattener_core_tb;

    localparam int COORD_W       = cbf_pkg::COORD_W;
    localparam int DPI_W         = cbf_pkg::DPI_W;
    localparam int CFG_IDX_W     = cbf_pkg::CFG_IDX_W;
    localparam int CFG_DAT_W     = cbf_pkg::CFG_DAT_W;
    localparam int SEGS          = cbf_pkg::SEGMENTS_DEF;
    localparam int CLK_HALF      = 10;
    localparam int STALL_LIMIT   = 4000;
    localparam int HOLD_CYCLES   = 400;
    localparam int HOLD_PHASE    = 7;
    localparam int SETTLE_CYCLES = 24;
    localparam int LAST_PHASE    = 8;

    // Index past the end of the register list; writes to it must be dropped.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] ctrl1_x;
        logic signed [COORD_W-1:0] ctrl1_y;
        logic signed [COORD_W-1:0] ctrl2_x;
        logic signed [COORD_W-1:0] ctrl2_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
    } t_curve_item;

    typedef struct packed {
        logic signed [COORD_W-1:0] x_dots;
        logic signed [COORD_W-1:0] y_dots;
        logic                      is_cut;
        logic                      final_point;
        logic                      accepted;
    } t_path_point;

    logic i_clk;
    logic i_rst_n;

    cbf_curve_if curve_if ();
    cbf_point_if point_if ();
    cbf_cfg_if   cfg_if ();

    cubic_bezier_flattener_core #(
        .SEGMENTS(SEGS)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_curve (curve_if.sink),
        .o_point (point_if.source),
        .i_cfg   (cfg_if.sink)
    );

    t_curve_item pending_curves[$];
    t_path_point expected_points[$];

    // Shadow copy of the configuration registers.
    logic             shadow_enabled;
    logic [DPI_W-1:0] shadow_dpi_x;
    logic [DPI_W-1:0] shadow_dpi_y;

    int          src_idle_pct;
    int          snk_idle_pct;
    int          phase_num;
    bit          curve_taken;
    int          hold_left;
    bit          hold_done;
    int          mismatches;
    int          stall_cycles;
    t_curve_item next_curve;
    t_path_point got_point;
    t_path_point want_point;

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Exact point on one axis at t = step/SEGS, scaled and rounded half up.
    function automatic logic signed [COORD_W-1:0] axis_dots(
        input longint p0, input longint p1, input longint p2, input longint p3,
        input longint step, input longint dpi);
        longint s3, c, b, a, acc, num, den, q;
        s3  = SEGS * SEGS * SEGS;
        c   = 3 * (p1 - p0);
        b   = 3 * (p2 - p1) - c;
        a   = (p3 - p0) - c - b;
        acc = p0 * s3 + c * step * SEGS * SEGS + b * step * step * SEGS
              + a * step * step * step;
        num = 2 * acc * dpi + s3 * 256;
        den = 2 * s3 * 256;
        q   = num / den;
        // Division truncates; pull negative remainders down to the floor.
        if ((num % den) != 0 && num < 0) q = q - 1;
        if (q > 32767) q = 32767;
        else if (q < -32768) q = -32768;
        return q[COORD_W-1:0];
    endfunction

    // Queue every path point that one transferred curve should produce.
    task automatic predict_path(input t_curve_item cv);
        t_path_point pt;
        if (!shadow_enabled) begin
            pt = '{x_dots: '0, y_dots: '0, is_cut: 1'b0, final_point: 1'b1,
                   accepted: 1'b0};
            expected_points.push_back(pt);
            return;
        end
        for (int i = 0; i <= SEGS; i++) begin
            pt.x_dots      = axis_dots(cv.start_x, cv.ctrl1_x, cv.ctrl2_x, cv.end_x,
                                       i, shadow_dpi_x);
            pt.y_dots      = axis_dots(cv.start_y, cv.ctrl1_y, cv.ctrl2_y, cv.end_y,
                                       i, shadow_dpi_y);
            pt.is_cut      = (i > 0);
            pt.final_point = (i == SEGS);
            pt.accepted    = 1'b1;
            expected_points.push_back(pt);
        end
    endtask

    // Mostly full-range coordinates, with extremes and small values mixed in.
    function automatic logic signed [COORD_W-1:0] rand_coord();
        case ($urandom_range(0, 9))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return COORD_W'($urandom_range(0, 511)) - 16'sd256;
            default: return COORD_W'($urandom);
        endcase
    endfunction

    task automatic add_curve(
        input logic [COORD_W-1:0] sx, input logic [COORD_W-1:0] sy,
        input logic [COORD_W-1:0] ax, input logic [COORD_W-1:0] ay,
        input logic [COORD_W-1:0] bx, input logic [COORD_W-1:0] by,
        input logic [COORD_W-1:0] ex, input logic [COORD_W-1:0] ey);
        pending_curves.push_back('{sx, sy, ax, ay, bx, by, ex, ey});
    endtask

    task automatic add_random_curve();
        add_curve(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                  rand_coord(), rand_coord(), rand_coord(), rand_coord());
    endtask

    // Hold one register write until the channel takes it; valid stays high.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] data);
        @(negedge i_clk);
        cfg_if.valid     <= 1'b1;
        cfg_if.reg_index <= idx;
        cfg_if.wr_data   <= data;
        do @(posedge i_clk); while (!cfg_if.ready);
    endtask

    // Write every register, plus a junk write to the unused index.
    task automatic set_config(input logic [CFG_DAT_W-1:0] en_data,
                              input logic [DPI_W-1:0] dx, input logic [DPI_W-1:0] dy);
        write_reg(REG_UNUSED, CFG_DAT_W'($urandom));
        write_reg(cbf_pkg::REG_ENABLED, en_data);
        write_reg(cbf_pkg::REG_DPI_X, dx);
        write_reg(cbf_pkg::REG_DPI_Y, dy);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    // Wait until all curves are taken and all points have come out.
    task automatic drain();
        while (pending_curves.size() != 0 || curve_if.valid || expected_points.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Curve driver: present the next pending curve once the last one transferred.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            curve_if.valid <= 1'b0;
        end else if (!curve_if.valid || curve_taken) begin
            curve_taken = 1'b0;
            if (pending_curves.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                next_curve = pending_curves.pop_front();
                curve_if.valid   <= 1'b1;
                curve_if.start_x <= next_curve.start_x;
                curve_if.start_y <= next_curve.start_y;
                curve_if.ctrl1_x <= next_curve.ctrl1_x;
                curve_if.ctrl1_y <= next_curve.ctrl1_y;
                curve_if.ctrl2_x <= next_curve.ctrl2_x;
                curve_if.ctrl2_y <= next_curve.ctrl2_y;
                curve_if.end_x   <= next_curve.end_x;
                curve_if.end_y   <= next_curve.end_y;
            end else begin
                curve_if.valid <= 1'b0;
            end
        end
    end

    // Point receiver: random stalls, and one long hold-off to back up the block.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            point_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left      <= hold_left - 1;
            point_if.ready <= 1'b0;
        end else if (phase_num == HOLD_PHASE && !hold_done && expected_points.size() != 0) begin
            hold_done      <= 1'b1;
            hold_left      <= HOLD_CYCLES;
            point_if.ready <= 1'b0;
        end else begin
            point_if.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    // Monitor: track register writes, predict on curve transfer, check points.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_if.valid && cfg_if.ready) begin
                case (cfg_if.reg_index)
                    cbf_pkg::REG_ENABLED: shadow_enabled = cfg_if.wr_data[0];
                    cbf_pkg::REG_DPI_X:   shadow_dpi_x   = cfg_if.wr_data[DPI_W-1:0];
                    cbf_pkg::REG_DPI_Y:   shadow_dpi_y   = cfg_if.wr_data[DPI_W-1:0];
                    default:              ;
                endcase
            end
            if (curve_if.valid && curve_if.ready) begin
                curve_taken = 1'b1;
                predict_path('{curve_if.start_x, curve_if.start_y, curve_if.ctrl1_x,
                               curve_if.ctrl1_y, curve_if.ctrl2_x, curve_if.ctrl2_y,
                               curve_if.end_x, curve_if.end_y});
            end
            if (point_if.valid && point_if.ready) begin
                got_point = '{point_if.x_dots, point_if.y_dots, point_if.is_cut,
                              point_if.final_point, point_if.accepted};
                if (expected_points.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected point: x=%0d y=%0d cut=%0b last=%0b acc=%0b",
                                 got_point.x_dots, got_point.y_dots, got_point.is_cut,
                                 got_point.final_point, got_point.accepted);
                end else begin
                    want_point = expected_points.pop_front();
                    if (got_point !== want_point) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $write("point mismatch: expected x=%0d y=%0d cut=%0b last=%0b acc=%0b",
                                   want_point.x_dots, want_point.y_dots,
                                   want_point.is_cut, want_point.final_point,
                                   want_point.accepted);
                            $display(", got x=%0d y=%0d cut=%0b last=%0b acc=%0b",
                                     got_point.x_dots, got_point.y_dots, got_point.is_cut,
                                     got_point.final_point, got_point.accepted);
                        end
                    end
                end
            end
            // Watchdog: count cycles with no transfer on any channel.
            if ((cfg_if.valid && cfg_if.ready) || (curve_if.valid && curve_if.ready) ||
                (point_if.valid && point_if.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("cubic_bezier_flattener_core verification failed");
                $finish;
            end
        end
    end

    // Stimulus sequence.
    initial begin
        int n_items;
        i_rst_n          = 1'b0;
        curve_if.valid   = 1'b0;
        curve_if.start_x = '0;
        curve_if.start_y = '0;
        curve_if.ctrl1_x = '0;
        curve_if.ctrl1_y = '0;
        curve_if.ctrl2_x = '0;
        curve_if.ctrl2_y = '0;
        curve_if.end_x   = '0;
        curve_if.end_y   = '0;
        point_if.ready   = 1'b0;
        cfg_if.valid     = 1'b0;
        cfg_if.reg_index = '0;
        cfg_if.wr_data   = '0;
        shadow_enabled   = 1'b0;
        shadow_dpi_x     = cbf_pkg::DPI_RESET;
        shadow_dpi_y     = cbf_pkg::DPI_RESET;
        src_idle_pct     = 34;
        snk_idle_pct     = 83;
        phase_num        = 0;
        curve_taken      = 1'b0;
        hold_left        = 0;
        hold_done        = 1'b0;
        mismatches       = 0;
        stall_cycles     = 0;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Disabled out of reset: each curve is rejected with a single point.
        add_curve(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                  16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        add_random_curve();
        drain();

        // Enable through a write with upper bits set; full scale on both axes.
        set_config(8'hFF, 8'd255, 8'd255);
        add_curve(16'h0000, 16'h0000, 16'h0000, 16'h0000,
                  16'h0000, 16'h0000, 16'h0000, 16'h0000);
        add_curve(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                  16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        add_curve(16'h8000, 16'h8000, 16'h8000, 16'h8000,
                  16'h8000, 16'h8000, 16'h8000, 16'h8000);
        // Widest coefficient swing on both axes.
        add_curve(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000,
                  16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
        add_curve(16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555,
                  16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555);
        // Closed loop and a straight line.
        add_curve(16'h1000, 16'hF000, 16'h7000, 16'h9000,
                  16'h9000, 16'h7000, 16'h1000, 16'hF000);
        add_curve(16'hC000, 16'hC000, 16'hE000, 16'hE000,
                  16'h2000, 16'h2000, 16'h4000, 16'h4000);
        drain();

        // Unit scale: constant half-dot points hit the rounding ties.
        set_config(8'h01, 8'd1, 8'd1);
        add_curve(16'h0080, 16'hFF80, 16'h0080, 16'hFF80,
                  16'h0080, 16'hFF80, 16'h0080, 16'hFF80);
        add_curve(16'h0180, 16'hFE80, 16'h0180, 16'hFE80,
                  16'h0180, 16'hFE80, 16'h0180, 16'hFE80);
        add_curve(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF,
                  16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
        drain();

        // Zero scale flattens every point to the origin.
        set_config(8'h01, 8'd0, 8'd0);
        add_random_curve();
        add_curve(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF,
                  16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
        drain();

        // Random phases over several register settings and idling patterns.
        for (int ph = 1; ph <= LAST_PHASE; ph++) begin
            phase_num = ph;
            if (ph <= 3) begin
                src_idle_pct = 34;
                snk_idle_pct = 83;
            end else if (ph <= 6) begin
                src_idle_pct = 83;
                snk_idle_pct = 34;
            end else begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            case (ph)
                1: set_config(8'h01, cbf_pkg::DPI_RESET, cbf_pkg::DPI_RESET);
                2: set_config(8'hFF, 8'd255, 8'd255);
                3: set_config(8'h01, 8'd1, 8'd1);
                4: set_config(8'hFE, DPI_W'($urandom), DPI_W'($urandom));
                5: set_config(8'h01, 8'd0, 8'd255);
                6: set_config({7'($urandom), 1'b1}, DPI_W'($urandom), DPI_W'($urandom));
                7: set_config(8'h01, 8'd255, 8'd1);
                default: set_config(8'h01, DPI_W'($urandom_range(1, 255)),
                                    DPI_W'($urandom_range(1, 255)));
            endcase
            n_items = (ph == 4) ? 20 : 60;
            repeat (n_items) add_random_curve();
            drain();
        end

        mismatches += expected_points.size();
        if (mismatches == 0) begin
            $display("cubic_bezier_flattener_core verification clean");
        end else begin
            $display("cubic_bezier_flattener_core verification failed");
        end
        $finish;
    end

endmodule
